### sv/tzsm_pkg.sv
`default_nettype none

package tzsm_pkg;

  // Serial divider: 33-bit numerator, one quotient bit per step
  localparam int unsigned DivSteps = 33;
  localparam int unsigned CntW     = 6;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_DIST,
    OP_DISARM,
    OP_ARM,
    OP_DIFF,
    OP_MUL_T,
    OP_MUL_W,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_SHOW_TENTHS,
    OP_SHOW_WHOLE,
    OP_SHOW_SAT,
    OP_TICK
  } op_t;

  // Datapath flags that the sequencer branches on
  typedef struct packed {
    logic mode;
    logic disp_on;
    logic dist_good;
    logic skip_arm;
    logic no_finish;
    logic dt_zero;
    logic div_more;
    logic quo_big;
  } stat_t;

  typedef struct packed {
    logic [1:0] digit_enable;
    logic [6:0] segments_n;
    logic       point_n;
    logic       showing;
    logic [6:0] shown_value;
    logic       in_tenths;
  } disp_t;

  // Common-anode segment patterns, a in bit 0
  function automatic logic [6:0] seg_of(input logic [3:0] digit);
    logic [6:0] s;
    case (digit)
      4'd0:    s = 7'h40;
      4'd1:    s = 7'h79;
      4'd2:    s = 7'h24;
      4'd3:    s = 7'h30;
      4'd4:    s = 7'h19;
      4'd5:    s = 7'h12;
      4'd6:    s = 7'h02;
      4'd7:    s = 7'h78;
      4'd8:    s = 7'h00;
      4'd9:    s = 7'h10;
      default: s = 7'h7F;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

### sv/two_zone_speed_meter_display_top.sv
`default_nettype none

// Channel  Direction  Handshake            Payload
// in       input      in_valid / in_stall  in_mode, in_echo_us, in_now_us
// out      output     out_valid/out_stall  out_digit_enable .. out_in_tenths
// cfg      input      APB write/read       cfg_paddr[4:2] selects the register
//
// One item at a time: a tick runs one more step while the display runs, and an echo
// that yields a speed runs the 33-step serial divider in the datapath, twice when the
// whole-m/s form needs a second division.
// Reset is synchronous and loads the register defaults and an idle display.
// A waiting result does not block the next transfer in; the sequencer
// holds on its last step only while the previous result is still stalled.

module two_zone_speed_meter_display_top (
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_mode,
  input  wire logic [14:0] in_echo_us,
  input  wire logic [31:0] in_now_us,

  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_digit_enable,
  output logic [6:0]       out_segments_n,
  output logic             out_point_n,
  output logic             out_showing,
  output logic [6:0]       out_shown_value,
  output logic             out_in_tenths,

  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [4:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  import tzsm_pkg::*;

  localparam logic [2:0] REG_FAR   = 3'd0;
  localparam logic [2:0] REG_NEAR  = 3'd1;
  localparam logic [2:0] REG_TOL   = 3'd2;
  localparam logic [2:0] REG_RANGE = 3'd3;
  localparam logic [2:0] REG_SHOW  = 3'd4;
  localparam logic [2:0] REG_MUX   = 3'd5;

  logic [8:0]  far_r, near_r, range_r;
  logic [5:0]  tol_r;
  logic [15:0] show_r;
  logic [7:0]  mux_r;
  logic [2:0]  reg_idx;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[4:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      far_r   <= 9'd60;
      near_r  <= 9'd30;
      tol_r   <= 6'd5;
      range_r <= 9'd300;
      show_r  <= 16'd3000;
      mux_r   <= 8'd5;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_FAR:   far_r   <= cfg_pwdata[8:0];
        REG_NEAR:  near_r  <= cfg_pwdata[8:0];
        REG_TOL:   tol_r   <= cfg_pwdata[5:0];
        REG_RANGE: range_r <= cfg_pwdata[8:0];
        REG_SHOW:  show_r  <= cfg_pwdata[15:0];
        REG_MUX:   mux_r   <= cfg_pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_FAR:   cfg_prdata = {23'd0, far_r};
      REG_NEAR:  cfg_prdata = {23'd0, near_r};
      REG_TOL:   cfg_prdata = {26'd0, tol_r};
      REG_RANGE: cfg_prdata = {23'd0, range_r};
      REG_SHOW:  cfg_prdata = {16'd0, show_r};
      REG_MUX:   cfg_prdata = {24'd0, mux_r};
      default:   cfg_prdata = 32'd0;
    endcase
  end

  logic    seq_idle, emit, in_xfer, out_free;
  op_t     op;
  stat_t   stat;
  disp_t   disp;
  logic    out_valid_r;
  disp_t   out_r;

  assign in_stall = !seq_idle;
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  tzsm_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_xfer),
    .out_free (out_free),
    .stat     (stat),
    .op       (op),
    .emit     (emit),
    .idle     (seq_idle)
  );

  tzsm_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (in_xfer),
    .in_mode    (in_mode),
    .in_echo_us (in_echo_us),
    .in_now_us  (in_now_us),
    .far_zone   (far_r),
    .near_zone  (near_r),
    .tolerance  (tol_r),
    .max_range  (range_r),
    .show_ms    (show_r),
    .mux_ms     (mux_r),
    .op         (op),
    .stat       (stat),
    .disp       (disp)
  );

  always_ff @(posedge clk) begin
    if (emit) begin
      out_r <= disp;
    end
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_digit_enable = out_r.digit_enable;
  assign out_segments_n   = out_r.segments_n;
  assign out_point_n      = out_r.point_n;
  assign out_showing      = out_r.showing;
  assign out_shown_value  = out_r.shown_value;
  assign out_in_tenths    = out_r.in_tenths;

  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> in_stall)
    else $error("input taken while an item is in progress");

  a_dark_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_showing) |->
      (out_segments_n == 7'h7F && out_digit_enable == 2'd0 && out_point_n))
    else $error("display lit with no speed shown");

endmodule

`default_nettype wire

### sv/tzsm_seq.sv
`default_nettype none

module tzsm_seq (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire logic            out_free,
  input  wire tzsm_pkg::stat_t stat,
  output tzsm_pkg::op_t        op,
  output logic                 emit,
  output logic                 idle
);
  import tzsm_pkg::*;

  typedef enum logic [3:0] {
    C_NEXT,
    C_ALWAYS,
    C_IDLE,
    C_TICK,
    C_DISP,
    C_NOT_DISP,
    C_GOOD,
    C_SKIP_ARM,
    C_NO_FINISH,
    C_DT_ZERO,
    C_DIV_MORE,
    C_BIG
  } cond_t;

  typedef struct packed {
    op_t        op;
    cond_t      cond;
    logic [4:0] target;
    logic       emit;
  } ucode_t;

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_CHECK   = 5'd8;
  localparam logic [4:0] S_DIV_T   = 5'd13;
  localparam logic [4:0] S_WHOLE   = 5'd16;
  localparam logic [4:0] S_DIV_W   = 5'd18;
  localparam logic [4:0] S_SAT     = 5'd20;
  localparam logic [4:0] S_TICK    = 5'd21;
  localparam logic [4:0] S_FIN     = 5'd23;
  localparam logic [4:0] S_GOOD    = 5'd6;

  function automatic ucode_t mk(input op_t o, input cond_t c, input logic [4:0] t,
                                input logic e);
    ucode_t u;
    u.op     = o;
    u.cond   = c;
    u.target = t;
    u.emit   = e;
    return u;
  endfunction

  function automatic ucode_t rom(input logic [4:0] a);
    ucode_t u;
    case (a)
      5'd0:    u = mk(OP_NOP,         C_IDLE,      S_IDLE,    1'b0);
      5'd1:    u = mk(OP_NOP,         C_TICK,      S_TICK,    1'b0);
      5'd2:    u = mk(OP_NOP,         C_DISP,      S_FIN,     1'b0);
      5'd3:    u = mk(OP_DIST,        C_NEXT,      S_IDLE,    1'b0);
      5'd4:    u = mk(OP_NOP,         C_GOOD,      S_GOOD,    1'b0);
      5'd5:    u = mk(OP_DISARM,      C_ALWAYS,    S_FIN,     1'b0);
      5'd6:    u = mk(OP_NOP,         C_SKIP_ARM,  S_CHECK,   1'b0);
      5'd7:    u = mk(OP_ARM,         C_NEXT,      S_IDLE,    1'b0);
      5'd8:    u = mk(OP_NOP,         C_NO_FINISH, S_FIN,     1'b0);
      5'd9:    u = mk(OP_DIFF,        C_NEXT,      S_IDLE,    1'b0);
      5'd10:   u = mk(OP_NOP,         C_DT_ZERO,   S_SAT,     1'b0);
      5'd11:   u = mk(OP_MUL_T,       C_NEXT,      S_IDLE,    1'b0);
      5'd12:   u = mk(OP_DIV_INIT,    C_NEXT,      S_IDLE,    1'b0);
      5'd13:   u = mk(OP_DIV_STEP,    C_DIV_MORE,  S_DIV_T,   1'b0);
      5'd14:   u = mk(OP_NOP,         C_BIG,       S_WHOLE,   1'b0);
      5'd15:   u = mk(OP_SHOW_TENTHS, C_ALWAYS,    S_FIN,     1'b0);
      5'd16:   u = mk(OP_MUL_W,       C_NEXT,      S_IDLE,    1'b0);
      5'd17:   u = mk(OP_DIV_INIT,    C_NEXT,      S_IDLE,    1'b0);
      5'd18:   u = mk(OP_DIV_STEP,    C_DIV_MORE,  S_DIV_W,   1'b0);
      5'd19:   u = mk(OP_SHOW_WHOLE,  C_ALWAYS,    S_FIN,     1'b0);
      5'd20:   u = mk(OP_SHOW_SAT,    C_ALWAYS,    S_FIN,     1'b0);
      5'd21:   u = mk(OP_NOP,         C_NOT_DISP,  S_FIN,     1'b0);
      5'd22:   u = mk(OP_TICK,        C_NEXT,      S_IDLE,    1'b0);
      5'd23:   u = mk(OP_NOP,         C_NEXT,      S_IDLE,    1'b1);
      default: u = mk(OP_NOP,         C_ALWAYS,    S_IDLE,    1'b0);
    endcase
    return u;
  endfunction

  logic [4:0] pc_r, pc_nxt;
  ucode_t     uc;
  logic       hit;

  assign uc = rom(pc_r);

  always_comb begin
    case (uc.cond)
      C_NEXT:      hit = 1'b0;
      C_ALWAYS:    hit = 1'b1;
      C_IDLE:      hit = !start;
      C_TICK:      hit = stat.mode;
      C_DISP:      hit = stat.disp_on;
      C_NOT_DISP:  hit = !stat.disp_on;
      C_GOOD:      hit = stat.dist_good;
      C_SKIP_ARM:  hit = stat.skip_arm;
      C_NO_FINISH: hit = stat.no_finish;
      C_DT_ZERO:   hit = stat.dt_zero;
      C_DIV_MORE:  hit = stat.div_more;
      C_BIG:       hit = stat.quo_big;
      default:     hit = 1'b0;
    endcase
  end

  always_comb begin
    if (uc.emit) begin
      // hold on the last step until the output register frees up
      pc_nxt = out_free ? S_IDLE : pc_r;
    end else if (hit) begin
      pc_nxt = uc.target;
    end else begin
      pc_nxt = pc_r + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= S_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  assign op   = uc.op;
  assign emit = uc.emit && out_free;
  assign idle = (pc_r == S_IDLE);

  a_emit_returns: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> idle)
    else $error("sequencer did not return to idle after a result");

  a_measure_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (idle && start) |=> (pc_r == 5'd1))
    else $error("sequencer missed an accepted item");

endmodule

`default_nettype wire

### sv/tzsm_dp.sv
`default_nettype none

module tzsm_dp (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            load,
  input  wire logic            in_mode,
  input  wire logic [14:0]     in_echo_us,
  input  wire logic [31:0]     in_now_us,
  input  wire logic [8:0]      far_zone,
  input  wire logic [8:0]      near_zone,
  input  wire logic [5:0]      tolerance,
  input  wire logic [8:0]      max_range,
  input  wire logic [15:0]     show_ms,
  input  wire logic [7:0]      mux_ms,
  input  wire tzsm_pkg::op_t   op,
  output tzsm_pkg::stat_t      stat,
  output tzsm_pkg::disp_t      disp
);
  import tzsm_pkg::*;

  // captured item
  logic        mode_r;
  logic [14:0] echo_r;
  logic [31:0] now_r;

  // work registers
  logic [13:0] d_r, d_nxt;
  logic [12:0] diff_r, diff_nxt;
  logic [31:0] dt_r, dt_nxt;
  logic [26:0] prod_r, prod_nxt;
  logic [32:0] num_r, num_nxt;
  logic [32:0] den_r, den_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;

  // block state
  logic        armed_r, armed_nxt;
  logic [12:0] first_d_r, first_d_nxt;
  logic [31:0] first_t_r, first_t_nxt;
  logic        disp_on_r, disp_on_nxt;
  logic [15:0] disp_el_r, disp_el_nxt;
  logic [7:0]  mux_el_r, mux_el_nxt;
  logic        left_r, left_nxt;
  logic [6:0]  value_r, value_nxt;
  logic        tenths_r, tenths_nxt;

  logic [23:0] dist_prod;
  logic [14:0] d_plus, far_lo, far_hi, near_lo, near_hi;
  logic        in_far, in_near;
  logic [13:0] fd_ext, diff_w;
  logic [26:0] mul_p;
  logic [33:0] shifted;
  logic        ge;
  logic [15:0] el_inc;
  logic [7:0]  mux_inc;

  assign dist_prod = {9'd0, echo_r} * 24'd281;

  // zone windows in sixteenths of a cm; lower edge compared as d + tol >= center
  assign d_plus  = {1'b0, d_r} + {5'd0, tolerance, 4'd0};
  assign far_lo  = {2'b0, far_zone, 4'd0};
  assign far_hi  = {1'b0, ({1'b0, far_zone} + {4'd0, tolerance}), 4'd0};
  assign near_lo = {2'b0, near_zone, 4'd0};
  assign near_hi = {1'b0, ({1'b0, near_zone} + {4'd0, tolerance}), 4'd0};
  assign in_far  = (d_plus >= far_lo) && ({1'b0, d_r} <= far_hi);
  assign in_near = (d_plus >= near_lo) && ({1'b0, d_r} <= near_hi);

  assign fd_ext = {1'b0, first_d_r};
  assign diff_w = (fd_ext > d_r) ? (fd_ext - d_r) : (d_r - fd_ext);

  assign mul_p = {14'd0, diff_r} * ((op == OP_MUL_T) ? 27'd12500 : 27'd1250);

  assign shifted = {rem_r, num_r[32]};
  assign ge      = (shifted >= {1'b0, den_r});

  assign el_inc  = disp_el_r + 16'd1;
  assign mux_inc = mux_el_r + 8'd1;

  always_comb begin
    stat.mode      = mode_r;
    stat.disp_on   = disp_on_r;
    stat.dist_good = (d_r != 14'd0) && ({1'b0, d_r} <= {2'b0, max_range, 4'd0});
    stat.skip_arm  = armed_r || !in_far;
    stat.no_finish = !armed_r || !in_near;
    stat.dt_zero   = (dt_r == 32'd0);
    stat.div_more  = (cnt_r != CntW'(1));
    stat.quo_big   = (num_r >= 33'd100);
  end

  always_comb begin
    d_nxt       = d_r;
    diff_nxt    = diff_r;
    dt_nxt      = dt_r;
    prod_nxt    = prod_r;
    num_nxt     = num_r;
    den_nxt     = den_r;
    rem_nxt     = rem_r;
    cnt_nxt     = cnt_r;
    armed_nxt   = armed_r;
    first_d_nxt = first_d_r;
    first_t_nxt = first_t_r;
    disp_on_nxt = disp_on_r;
    disp_el_nxt = disp_el_r;
    mux_el_nxt  = mux_el_r;
    left_nxt    = left_r;
    value_nxt   = value_r;
    tenths_nxt  = tenths_r;
    case (op)
      OP_DIST: begin
        d_nxt = dist_prod[23:10];
      end
      OP_DISARM: begin
        armed_nxt = 1'b0;
      end
      OP_ARM: begin
        armed_nxt   = 1'b1;
        first_d_nxt = d_r[12:0];
        first_t_nxt = now_r;
      end
      OP_DIFF: begin
        diff_nxt = diff_w[12:0];
        dt_nxt   = now_r - first_t_r;
      end
      OP_MUL_T, OP_MUL_W: begin
        prod_nxt = mul_p;
      end
      OP_DIV_INIT: begin
        // round half up: (n + dt) / (2 dt)
        num_nxt = {6'd0, prod_r} + {1'b0, dt_r};
        den_nxt = {dt_r, 1'b0};
        rem_nxt = '0;
        cnt_nxt = CntW'(DivSteps);
      end
      OP_DIV_STEP: begin
        rem_nxt = ge ? 33'(shifted - {1'b0, den_r}) : shifted[32:0];
        num_nxt = {num_r[31:0], ge};
        cnt_nxt = cnt_r - CntW'(1);
      end
      OP_SHOW_TENTHS, OP_SHOW_WHOLE, OP_SHOW_SAT: begin
        if (op == OP_SHOW_TENTHS) begin
          value_nxt  = num_r[6:0];
          tenths_nxt = 1'b1;
        end else if (op == OP_SHOW_WHOLE && num_r <= 33'd99) begin
          value_nxt  = num_r[6:0];
          tenths_nxt = 1'b0;
        end else begin
          value_nxt  = 7'd99;
          tenths_nxt = 1'b0;
        end
        disp_on_nxt = 1'b1;
        disp_el_nxt = 16'd0;
        mux_el_nxt  = 8'd0;
        left_nxt    = !left_r;
      end
      OP_TICK: begin
        disp_el_nxt = el_inc;
        if (el_inc >= show_ms) begin
          disp_on_nxt = 1'b0;
          armed_nxt   = 1'b0;
        end else if (mux_inc >= mux_ms) begin
          mux_el_nxt = 8'd0;
          left_nxt   = !left_r;
        end else begin
          mux_el_nxt = mux_inc;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (load) begin
      mode_r <= in_mode;
      echo_r <= in_echo_us;
      now_r  <= in_now_us;
    end
    d_r    <= d_nxt;
    diff_r <= diff_nxt;
    dt_r   <= dt_nxt;
    prod_r <= prod_nxt;
    num_r  <= num_nxt;
    den_r  <= den_nxt;
    rem_r  <= rem_nxt;
    if (!rst_n) begin
      cnt_r     <= '0;
      armed_r   <= 1'b0;
      first_d_r <= '0;
      first_t_r <= '0;
      disp_on_r <= 1'b0;
      disp_el_r <= '0;
      mux_el_r  <= '0;
      left_r    <= 1'b1;
      value_r   <= '0;
      tenths_r  <= 1'b0;
    end else begin
      cnt_r     <= cnt_nxt;
      armed_r   <= armed_nxt;
      first_d_r <= first_d_nxt;
      first_t_r <= first_t_nxt;
      disp_on_r <= disp_on_nxt;
      disp_el_r <= disp_el_nxt;
      mux_el_r  <= mux_el_nxt;
      left_r    <= left_nxt;
      value_r   <= value_nxt;
      tenths_r  <= tenths_nxt;
    end
  end

  // digit split: tens = v * 205 >> 11 is exact below 1029
  logic [14:0] tens_p;
  logic [3:0]  tens;
  logic [6:0]  ones_w;
  logic        left_lit;

  assign tens_p   = {8'd0, value_r} * 15'd205;
  assign tens     = tens_p[14:11];
  assign ones_w   = value_r - {tens, 3'd0} - {2'd0, tens, 1'b0};
  assign left_lit = !left_r;

  always_comb begin
    if (!disp_on_r) begin
      disp.digit_enable = 2'd0;
      disp.segments_n   = 7'h7F;
      disp.point_n      = 1'b1;
      disp.showing      = 1'b0;
      disp.shown_value  = 7'd0;
      disp.in_tenths    = 1'b0;
    end else begin
      disp.digit_enable = left_lit ? 2'd1 : 2'd2;
      disp.segments_n   = seg_of(left_lit ? tens : ones_w[3:0]);
      disp.point_n      = !(left_lit && tenths_r);
      disp.showing      = 1'b1;
      disp.shown_value  = value_r;
      disp.in_tenths    = tenths_r;
    end
  end

  a_disp_needs_arm: assert property (@(posedge clk) disable iff (!rst_n)
    disp_on_r |-> armed_r)
    else $error("display running without an armed capture");

  a_tenths_range: assert property (@(posedge clk) disable iff (!rst_n)
    tenths_r |-> (value_r < 7'd100))
    else $error("tenths value does not fit two digits");

  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    (op == OP_DIV_STEP) |-> (cnt_r != '0))
    else $error("divider stepped past its last bit");

endmodule

`default_nettype wire

### bench/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum int {
    REG_FAR_ZONE,
    REG_NEAR_ZONE,
    REG_TOLERANCE,
    REG_MAX_RANGE,
    REG_SHOW_MS,
    REG_MUX_MS
  } reg_t;

  localparam logic       MODE_ECHO   = 1'b0;
  localparam logic       MODE_TICK   = 1'b1;
  localparam logic [1:0] DIGITS_DARK = 2'd0;
  localparam logic [1:0] DIGIT_LEFT  = 2'd1;
  localparam logic [1:0] DIGIT_RIGHT = 2'd2;
  localparam logic [6:0] SEGS_DARK   = 7'h7F;
  localparam int         QUIET_LIMIT = 3000;
  localparam int         HOLD_CYCLES = 400;
  localparam int         SETTLE      = 100;
  localparam int         ECHO_MAX    = 30000;

  // Tracks the meter state and the display frames still owed by the block
  class meter_tracker;
    logic [8:0]  far_cm, near_cm, range_cm;
    logic [5:0]  tol_cm;
    logic [15:0] show_len;
    logic [7:0]  mux_len;
    bit          armed, lit, left_next, speed_tenths;
    logic [12:0] start_dist;
    logic [31:0] start_us;
    logic [15:0] lit_ms;
    logic [7:0]  mux_cnt;
    logic [6:0]  speed_val;
    tzsm_pkg::disp_t frames_due[$];
    int          errors;

    function new();
      far_cm = 60; near_cm = 30; tol_cm = 5; range_cm = 300;
      show_len = 3000; mux_len = 5;
      armed = 0; start_dist = 0; start_us = 0;
      lit = 0; lit_ms = 0; mux_cnt = 0; left_next = 1;
      speed_val = 0; speed_tenths = 0;
      errors = 0;
    endfunction

    function void set_reg(reg_t idx, logic [31:0] val);
      case (idx)
        REG_FAR_ZONE:  far_cm   = val[8:0];
        REG_NEAR_ZONE: near_cm  = val[8:0];
        REG_TOLERANCE: tol_cm   = val[5:0];
        REG_MAX_RANGE: range_cm = val[8:0];
        REG_SHOW_MS:   show_len = val[15:0];
        REG_MUX_MS:    mux_len  = val[7:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return frames_due.size();
    endfunction

    function bit in_window(int unsigned d16, logic [8:0] center);
      int c, t, lo, hi;
      c = center;
      t = tol_cm;
      lo = (c - t) * 16;
      hi = (c + t) * 16;
      return int'(d16) >= lo && int'(d16) <= hi;
    endfunction

    // Round half up to tenths; fall back to whole m/s once tenths need three digits
    function void hold_speed(int unsigned diff, logic [31:0] dt);
      logic [63:0] den, q;
      if (dt == 0) begin
        speed_val = 7'd99;
        speed_tenths = 0;
        return;
      end
      den = {31'b0, dt, 1'b0};
      q = (64'(diff) * 64'd12500 + 64'(dt)) / den;
      if (q < 100) begin
        speed_val = q[6:0];
        speed_tenths = 1;
      end else begin
        q = (64'(diff) * 64'd1250 + 64'(dt)) / den;
        speed_val = (q > 99) ? 7'd99 : q[6:0];
        speed_tenths = 0;
      end
    endfunction

    function logic [6:0] digit_segments(int unsigned digit);
      logic [7:0] pat;
      case (digit)
        0: pat = 8'hC0;
        1: pat = 8'hF9;
        2: pat = 8'hA4;
        3: pat = 8'hB0;
        4: pat = 8'h99;
        5: pat = 8'h92;
        6: pat = 8'h82;
        7: pat = 8'hF8;
        8: pat = 8'h80;
        default: pat = 8'h90;
      endcase
      return pat[6:0];
    endfunction

    function void take_item(logic mode, logic [14:0] echo, logic [31:0] now);
      int unsigned d16, diff, v;
      tzsm_pkg::disp_t f;
      if (mode == MODE_TICK) begin
        if (lit) begin
          lit_ms = lit_ms + 16'd1;
          if (lit_ms >= show_len) begin
            lit = 0;
            armed = 0;
          end else begin
            mux_cnt = mux_cnt + 8'd1;
            if (mux_cnt >= mux_len) begin
              mux_cnt = 0;
              left_next = !left_next;
            end
          end
        end
      end else if (!lit) begin
        d16 = (32'(echo) * 281) >> 10;
        if (d16 == 0 || d16 > 32'(range_cm) * 16) begin
          armed = 0;
        end else begin
          if (!armed && in_window(d16, far_cm)) begin
            armed = 1;
            start_dist = d16[12:0];
            start_us = now;
          end
          if (armed && in_window(d16, near_cm)) begin
            diff = (32'(start_dist) > d16) ? 32'(start_dist) - d16 : d16 - 32'(start_dist);
            hold_speed(diff, now - start_us);
            lit = 1;
            lit_ms = 0;
            mux_cnt = 0;
            left_next = !left_next;
          end
        end
      end
      if (!lit) begin
        f = {DIGITS_DARK, SEGS_DARK, 1'b1, 1'b0, 7'd0, 1'b0};
      end else begin
        // left_next low means the left digit was the one just lit
        v = speed_val % 100;
        f.digit_enable = left_next ? DIGIT_RIGHT : DIGIT_LEFT;
        f.segments_n = digit_segments(left_next ? v % 10 : v / 10);
        f.point_n = !(!left_next && speed_tenths);
        f.showing = 1'b1;
        f.shown_value = speed_val;
        f.in_tenths = speed_tenths;
      end
      frames_due.push_back(f);
    endfunction

    function void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void match_frame(tzsm_pkg::disp_t got);
      tzsm_pkg::disp_t want;
      if (frames_due.size() == 0) begin
        $error("display frame arrived with none outstanding");
        errors++;
        return;
      end
      want = frames_due.pop_front();
      check_field("digit_enable", want.digit_enable, got.digit_enable);
      check_field("segments_n", want.segments_n, got.segments_n);
      check_field("point_n", want.point_n, got.point_n);
      check_field("showing", want.showing, got.showing);
      check_field("shown_value", want.shown_value, got.shown_value);
      check_field("in_tenths", want.in_tenths, got.in_tenths);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_mode;
  logic [14:0] in_echo_us;
  logic [31:0] in_now_us;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_digit_enable;
  logic [6:0]  out_segments_n;
  logic        out_point_n;
  logic        out_showing;
  logic [6:0]  out_shown_value;
  logic        out_in_tenths;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [4:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  meter_tracker sb;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_asked = 0;
  int hold_served = 0;
  int hold_left = 0;
  int quiet = 0;
  int sent = 0;

  two_zone_speed_meter_display_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_echo_us       (in_echo_us),
    .in_now_us        (in_now_us),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_digit_enable (out_digit_enable),
    .out_segments_n   (out_segments_n),
    .out_point_n      (out_point_n),
    .out_showing      (out_showing),
    .out_shown_value  (out_shown_value),
    .out_in_tenths    (out_in_tenths),
    .cfg_psel         (cfg_psel),
    .cfg_penable      (cfg_penable),
    .cfg_pwrite       (cfg_pwrite),
    .cfg_paddr        (cfg_paddr),
    .cfg_pwdata       (cfg_pwdata),
    .cfg_prdata       (cfg_prdata),
    .cfg_pready       (cfg_pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Receiver: random stalls, or a long hold-off when one is asked for
  always @(posedge clk) begin
    if (hold_asked != hold_served) begin
      hold_served <= hold_asked;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.match_frame({out_digit_enable, out_segments_n, out_point_n, out_showing,
                      out_shown_value, out_in_tenths});
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        quiet <= 0;
      else
        quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  function automatic logic [31:0] reg_mask(reg_t idx);
    case (idx)
      REG_TOLERANCE: return 32'h3F;
      REG_SHOW_MS:   return 32'hFFFF;
      REG_MUX_MS:    return 32'hFF;
      default:       return 32'h1FF;
    endcase
  endfunction

  function automatic logic [14:0] echo_at(int d16);
    int e;
    e = (d16 * 1024 + 280) / 281;
    if (e > ECHO_MAX) e = ECHO_MAX;
    return 15'(e);
  endfunction

  // Echo width that lands somewhere in the window around a zone center
  function automatic logic [14:0] echo_near(logic [8:0] center, logic [5:0] tol);
    int span, off, d;
    span = int'(tol) * 16;
    off = $urandom_range(0, 2 * span);
    d = int'(center) * 16 + off - span;
    if (d < 1) d = 1;
    return echo_at(d);
  endfunction

  task automatic cfg_write(reg_t idx, logic [31:0] val);
    logic [31:0] want;
    want = val & reg_mask(idx);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= 5'(int'(idx) * 4);
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    sb.set_reg(idx, val);
    @(posedge clk);
    // read back through the same port
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== want) begin
      $error("register %0d readback: expected %0d, got %0d", int'(idx), want, cfg_prdata);
      sb.errors++;
    end
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic cfg_all(int far_cm, int near_cm, int tol_cm, int range_cm, int show,
                         int mux);
    cfg_write(REG_FAR_ZONE, far_cm);
    cfg_write(REG_NEAR_ZONE, near_cm);
    cfg_write(REG_TOLERANCE, tol_cm);
    cfg_write(REG_MAX_RANGE, range_cm);
    cfg_write(REG_SHOW_MS, show);
    cfg_write(REG_MUX_MS, mux);
  endtask

  task automatic cfg_random();
    int far_cm, tol_cm;
    far_cm = $urandom_range(30, 200);
    tol_cm = $urandom_range(0, 15);
    cfg_all(far_cm, $urandom_range(5, 100), tol_cm, $urandom_range(far_cm + tol_cm, 511),
            $urandom_range(0, 10), $urandom_range(0, 4));
  endtask

  task automatic send_item(logic mode, logic [14:0] echo, logic [31:0] now);
    if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_mode <= mode;
    in_echo_us <= echo;
    in_now_us <= now;
    do @(posedge clk); while (in_stall);
    sb.take_item(mode, echo, now);
    sent++;
  endtask

  task automatic send_tick();
    send_item(MODE_TICK, 15'($urandom_range(0, ECHO_MAX)), $urandom);
  endtask

  // Hold off new transfers until every owed frame has come back
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // One pass past the sensor: far zone, maybe noise, near zone, then the display ticks
  task automatic run_pass();
    logic [31:0] t0, dt;
    int n;
    t0 = $urandom;
    send_item(MODE_ECHO, echo_near(sb.far_cm, sb.tol_cm), t0);
    if ($urandom_range(0, 4) == 0)
      send_item(MODE_ECHO, 15'($urandom_range(0, ECHO_MAX)), t0 + $urandom_range(0, 1000));
    case ($urandom_range(0, 4))
      0: dt = 0;
      1: dt = $urandom_range(1, 3000);
      2: dt = $urandom_range(3000, 50000);
      default: dt = $urandom_range(50000, 600000);
    endcase
    send_item(MODE_ECHO, echo_near(sb.near_cm, sb.tol_cm), t0 + dt);
    n = (sb.show_len > 30 ? 30 : int'(sb.show_len)) + $urandom_range(0, 2);
    repeat (n) begin
      if ($urandom_range(0, 9) == 0)
        send_item(MODE_ECHO, 15'($urandom_range(0, ECHO_MAX)), $urandom);
      send_tick();
    end
  endtask

  task automatic run_phase(int n_items, int idle, int stall);
    int start;
    send_idle_pct = idle;
    stall_pct = stall;
    start = sent;
    while (sent - start < n_items) begin
      if ($urandom_range(0, 99) < 15)
        send_item(1'($urandom_range(0, 1)), 15'($urandom_range(0, ECHO_MAX)), $urandom);
      else
        run_pass();
    end
  endtask

  initial begin
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_mode = MODE_ECHO;
    in_echo_us = '0;
    in_now_us = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: short display, digit swap on every tick
    cfg_all(60, 30, 5, 300, 3, 0);
    send_tick();
    send_item(MODE_ECHO, 15'd0, 32'd0);
    send_item(MODE_ECHO, 15'(ECHO_MAX), 32'd0);
    send_item(MODE_ECHO, echo_at(960), 32'hFFFF_FF00);
    send_item(MODE_ECHO, echo_at(720), 32'hFFFF_FF80);
    // timestamp wraps between the two zones, fast enough to saturate
    send_item(MODE_ECHO, echo_at(480), 32'h0000_0100);
    send_item(MODE_ECHO, echo_at(960), 32'h0000_0200);
    repeat (3) send_tick();
    send_item(MODE_ECHO, echo_at(960), 32'd1000);
    send_item(MODE_ECHO, echo_at(480), 32'd101000);
    repeat (3) send_tick();
    send_item(MODE_ECHO, echo_at(960), 32'd5000);
    send_item(MODE_ECHO, echo_at(480), 32'd15000);
    repeat (3) send_tick();
    // no time between the two echoes
    send_item(MODE_ECHO, echo_at(960), 32'd7);
    send_item(MODE_ECHO, echo_at(480), 32'd7);
    repeat (3) send_tick();
    drain();

    cfg_random();
    hold_asked <= hold_asked + 1;
    run_phase(40, 0, 0);
    drain();
    run_phase(40, 0, 0);
    drain();

    // Top of every register: zones overlap and the display never times out here
    cfg_all(511, 511, 63, 511, 65535, 255);
    run_phase(20, 0, 0);
    drain();

    cfg_random();
    run_phase(80, 81, 0);
    drain();

    // Far window dips below zero, display ends on the first tick
    cfg_all(0, 10, 63, 100, 0, 0);
    run_phase(20, 0, 81);
    drain();

    cfg_random();
    run_phase(80, 0, 81);
    drain();

    cfg_all(0, 0, 0, 0, 1, 1);
    run_phase(10, 26, 26);
    drain();

    cfg_random();
    run_phase(80, 26, 26);
    drain();

    if (sb.errors == 0 && sb.pending() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

### sim.f
sv/tzsm_pkg.sv
sv/tzsm_seq.sv
sv/tzsm_dp.sv
sv/two_zone_speed_meter_display_top.sv
bench/tb.sv
